// ===== rtl/edf_process_scheduler_macros.svh =====
// Assertion helpers for the scheduler; each expects clk and arst_n in scope.
`ifndef EDF_PROCESS_SCHEDULER_MACROS_SVH
`define EDF_PROCESS_SCHEDULER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define EDF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define EDF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/edf_pkg.sv =====
`default_nettype none
package edf_pkg;

	localparam logic [2:0] ST_LOADED = 3'd0;
	localparam logic [2:0] ST_RAN    = 3'd1;
	localparam logic [2:0] ST_IDLE   = 3'd2;
	localparam logic [2:0] ST_DONE   = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_STEP = 1'b1;

	localparam logic REG_SWITCH_OVERHEAD = 1'b0;

	// Running summary of the slots seen so far along the chain.
	typedef struct packed {
		logic        any_left;
		logic        pick_valid;
		logic [15:0] pick_dl;
		logic [16:0] pick_rem;
		logic        free_valid;
	} scan_rec_t;

	// Slot update broadcast to all cells; the target slot index travels beside it.
	typedef struct packed {
		logic        load;
		logic        run;
		logic [15:0] arrival;
		logic [16:0] remaining;
		logic [15:0] deadline;
	} slot_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/edf_cell.sv =====
`default_nettype none
module edf_cell #(
	parameter int NUM_SLOTS = 16,
	parameter int IDX = 0
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire edf_pkg::scan_rec_t           rec_in,
	input  wire logic [$clog2(NUM_SLOTS)-1:0] pidx_in,
	input  wire logic [$clog2(NUM_SLOTS)-1:0] fidx_in,
	input  wire logic [31:0]                  now_tick,
	input  wire edf_pkg::slot_cmd_t           cmd,
	input  wire logic [$clog2(NUM_SLOTS)-1:0] wr_idx,
	output edf_pkg::scan_rec_t                rec_out,
	output logic [$clog2(NUM_SLOTS)-1:0]      pidx_out,
	output logic [$clog2(NUM_SLOTS)-1:0]      fidx_out
);
	import edf_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic        valid_q;
	logic        done_q;
	logic [15:0] arrival_q;
	logic [16:0] rem_q;
	logic [15:0] dl_q;

	scan_rec_t     rec_q;
	logic [IW-1:0] pidx_q;
	logic [IW-1:0] fidx_q;

	logic      live;
	logic      ready;
	logic      take_pick;
	logic      take_free;
	logic      hit;
	scan_rec_t rec_nxt;

	assign live      = valid_q && !done_q;
	assign ready     = live && ({16'b0, arrival_q} <= now_tick);
	// strict compare keeps the lower slot on a tie
	assign take_pick = ready && (!rec_in.pick_valid || dl_q < rec_in.pick_dl);
	assign take_free = !rec_in.free_valid && !valid_q;
	assign hit       = (wr_idx == MY_IDX);

	always_comb begin
		rec_nxt = rec_in;
		rec_nxt.any_left = rec_in.any_left | live;
		if (take_pick) begin
			rec_nxt.pick_valid = 1'b1;
			rec_nxt.pick_dl    = dl_q;
			rec_nxt.pick_rem   = rem_q;
		end
		if (take_free) begin
			rec_nxt.free_valid = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rec_q  <= rec_nxt;
		pidx_q <= take_pick ? MY_IDX : pidx_in;
		fidx_q <= take_free ? MY_IDX : fidx_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (hit && cmd.load) begin
			valid_q <= 1'b1;
			done_q  <= 1'b0;
		end else if (hit && cmd.run && rem_q <= 17'd1) begin
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && cmd.load) begin
			arrival_q <= cmd.arrival;
			rem_q     <= cmd.remaining;
			dl_q      <= cmd.deadline;
		end else if (hit && cmd.run) begin
			rem_q <= (rem_q <= 17'd1) ? 17'd0 : rem_q - 17'd1;
		end
	end

	assign rec_out  = rec_q;
	assign pidx_out = pidx_q;
	assign fidx_out = fidx_q;

endmodule
`default_nettype wire

// ===== rtl/edf_process_scheduler.sv =====
`default_nettype none
`include "edf_process_scheduler_macros.svh"
// Earliest-deadline-first scheduler over NUM_SLOTS process slots. Each item
// (load or step) passes through the scan state, in which the scan record
// hops one slot cell per cycle down the chain, then the finish state, which
// applies the slot update and registers the result, and then the result
// cycle itself. busy drops in the result cycle, so a new start can be taken
// there; a new item is not taken while busy, so items do not overlap.
// result_valid is high for exactly one cycle and the result cannot be held
// off.
module edf_process_scheduler #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        req_type,
	input  wire logic [15:0] arrival_time,
	input  wire logic [15:0] exec_time,
	input  wire logic [15:0] due_deadline,
	output logic             result_valid,
	output logic [2:0]       status,
	output logic [4:0]       proc_id,
	output logic [31:0]      run_tick,
	output logic             finished,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import edf_pkg::*;

	localparam int IW = $clog2(NUM_SLOTS);
	localparam logic [IW-1:0] LAST_CNT = IW'(NUM_SLOTS - 1);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]    state_q;
	logic [IW-1:0] cnt_q;
	logic          req_q;
	logic [15:0]   arr_q;
	logic [15:0]   exe_q;
	logic [15:0]   dl_q;
	logic [31:0]   now_q;
	logic [7:0]    ovh_q;
	logic [IW-1:0] last_idx_q;
	logic          has_run_q;

	logic          result_valid_q;
	logic [2:0]    status_q;
	logic [4:0]    proc_id_q;
	logic [31:0]   run_tick_q;
	logic          finished_q;

	scan_rec_t     rec   [NUM_SLOTS+1];
	logic [IW-1:0] pidx  [NUM_SLOTS+1];
	logic [IW-1:0] fidx  [NUM_SLOTS+1];

	slot_cmd_t     cmd;
	logic [IW-1:0] wr_idx;
	scan_rec_t     fin_rec;
	logic          accept;
	logic          cfg_wr;

	logic [IW-1:0] sel_idx;
	logic [IW:0]   sel_id;
	logic [IW+5:0] sel_id_ext;
	logic          do_switch;
	logic [31:0]   disp_tick;
	logic [2:0]    res_status;
	logic [31:0]   res_tick;
	logic          res_fin;
	logic          res_has_id;
	logic [31:0]   now_nxt;
	logic          run_upd;

	assign accept  = start && !busy;
	assign busy    = (state_q != S_IDLE);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign prdata  = (paddr[2] == REG_SWITCH_OVERHEAD) ? {24'b0, ovh_q} : 32'b0;

	assign rec[0]  = '0;
	assign pidx[0] = '0;
	assign fidx[0] = '0;
	assign fin_rec = rec[NUM_SLOTS];

	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		edf_cell #(
			.NUM_SLOTS(NUM_SLOTS),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.rec_in(rec[i]),
			.pidx_in(pidx[i]),
			.fidx_in(fidx[i]),
			.now_tick(now_q),
			.cmd(cmd),
			.wr_idx(wr_idx),
			.rec_out(rec[i+1]),
			.pidx_out(pidx[i+1]),
			.fidx_out(fidx[i+1])
		);
	end

	assign sel_idx    = (req_q == REQ_LOAD) ? fidx[NUM_SLOTS] : pidx[NUM_SLOTS];
	assign sel_id     = {1'b0, sel_idx} + (IW+1)'(1);
	assign sel_id_ext = (IW+6)'(sel_id);
	assign do_switch  = has_run_q && (last_idx_q != pidx[NUM_SLOTS]);
	assign disp_tick  = now_q + (do_switch ? {24'b0, ovh_q} : 32'b0);

	// Decide the outcome from the record that left the last cell.
	always_comb begin
		cmd            = '0;
		cmd.arrival    = arr_q;
		cmd.remaining  = {1'b0, exe_q};
		cmd.deadline   = dl_q;
		wr_idx         = sel_idx;
		res_status     = ST_FULL;
		res_tick       = 32'b0;
		res_fin        = 1'b0;
		res_has_id     = 1'b0;
		now_nxt        = now_q;
		run_upd        = 1'b0;
		if (req_q == REQ_LOAD) begin
			if (fin_rec.free_valid) begin
				cmd.load   = (state_q == S_FINISH);
				res_status = ST_LOADED;
				res_has_id = 1'b1;
			end
		end else if (!fin_rec.any_left) begin
			res_status = ST_DONE;
			res_tick   = now_q;
		end else if (!fin_rec.pick_valid) begin
			res_status = ST_IDLE;
			res_tick   = now_q;
			now_nxt    = now_q + 32'd1;
		end else begin
			cmd.run    = (state_q == S_FINISH);
			res_status = ST_RAN;
			res_tick   = disp_tick;
			res_fin    = (fin_rec.pick_rem <= 17'd1);
			res_has_id = 1'b1;
			now_nxt    = disp_tick + 32'd1;
			run_upd    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			now_q          <= 32'b0;
			ovh_q          <= 8'b0;
			last_idx_q     <= '0;
			has_run_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_wr && paddr[2] == REG_SWITCH_OVERHEAD) begin
				ovh_q <= pwdata[7:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
					end
				end
				S_SCAN: begin
					// hold until the record has passed every cell
					if (cnt_q == LAST_CNT) begin
						state_q <= S_FINISH;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_FINISH: begin
					state_q        <= S_IDLE;
					result_valid_q <= 1'b1;
					now_q          <= now_nxt;
					if (run_upd) begin
						last_idx_q <= pidx[NUM_SLOTS];
						has_run_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			arr_q <= arrival_time;
			exe_q <= exec_time;
			dl_q  <= due_deadline;
		end
		if (state_q == S_FINISH) begin
			status_q   <= res_status;
			proc_id_q  <= res_has_id ? sel_id_ext[4:0] : 5'd0;
			run_tick_q <= res_tick;
			finished_q <= res_fin;
		end
	end

	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign proc_id      = proc_id_q;
	assign run_tick     = run_tick_q;
	assign finished     = finished_q;

	`EDF_ASSERT_NEXT(a_accept_busy, accept, busy, "busy not raised after an accepted item")
	`EDF_ASSERT_NEXT(a_finish_result, state_q == S_FINISH, result_valid_q,
		"finish cycle did not produce a result")
	`EDF_ASSERT_NEXT(a_single_strobe, result_valid_q, !result_valid_q,
		"result strobe longer than one cycle")
	`EDF_ASSERT_NOW(a_result_idle, result_valid_q, !busy || state_q == S_SCAN,
		"result shown while the block is not free")

endmodule
`default_nettype wire
